// ===== hw/rtl/fixed_rate_deadline_scheduler_unit_assert.svh =====
// assertion macros for the fixed rate deadline scheduler
`ifndef FIXED_RATE_DEADLINE_SCHEDULER_UNIT_ASSERT_SVH
`define FIXED_RATE_DEADLINE_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication, checked on every clock edge outside reset
`define FRDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every clock edge outside reset
`define FRDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/frds_pkg.sv =====
// shared types and constants of the fixed rate deadline scheduler
package frds_pkg;

  localparam int unsigned CFG_INDEX_BITS = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD       = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COUNTER_MASK = 2'd1;

  localparam logic [31:0] RESET_PERIOD = 32'd1000;
  localparam logic [31:0] MIN_MASK     = 32'h0000_FFFF;

  // settings handed from the register block to the scheduling core
  typedef struct packed {
    logic [31:0] period;
    logic        period_err;
    logic        restart;
  } cfg_t;

  // one result transaction
  typedef struct packed {
    logic        fired;
    logic [31:0] interval;
    logic [31:0] lateness;
    logic        overran;
    logic [31:0] release_count;
    logic [31:0] overrun_count;
    logic [31:0] worst_lateness;
    logic        period_error;
  } res_t;

endpackage

// ===== hw/rtl/frds_if.sv =====
// valid/ready channels for polls and results

// poll channel: one counter sample per transaction
interface frds_poll_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_time;

  modport source (output valid, output now_time, input ready);
  modport sink (input valid, input now_time, output ready);
endinterface

// result channel: one scheduling decision per transaction
interface frds_result_if;
  logic        valid;
  logic        ready;
  logic        fired;
  logic [31:0] interval;
  logic [31:0] lateness;
  logic        overran;
  logic [31:0] release_count;
  logic [31:0] overrun_count;
  logic [31:0] worst_lateness;
  logic        period_error;

  modport source (
    output valid, output fired, output interval, output lateness, output overran,
    output release_count, output overrun_count, output worst_lateness,
    output period_error, input ready
  );
  modport sink (
    input valid, input fired, input interval, input lateness, input overran,
    input release_count, input overrun_count, input worst_lateness,
    input period_error, output ready
  );
endinterface

// ===== hw/rtl/fixed_rate_deadline_scheduler_unit.sv =====
// Fixed rate deadline scheduler. Each poll transaction carries a free-running
// counter sample; the block answers with one result transaction saying whether
// a periodic release is due, with its interval, lateness, overrun flag and
// running statistics. After reset or a period write the first poll fires if
// the period is valid. One poll per clock while results are taken; a poll
// passes the poll register, then the result register, with the whole
// decision made by the single-cycle logic between them. Write configuration
// only while no poll is in flight. COUNTER_BITS (16 to 32) sets the widest counter handled.
`include "fixed_rate_deadline_scheduler_unit_assert.svh"

module fixed_rate_deadline_scheduler_unit
  import frds_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [31:0]               cfg_data,
  frds_poll_if.sink                 poll,
  frds_result_if.source             result
);

  cfg_t                    cfg;
  logic [COUNTER_BITS-1:0] mask;

  logic                    in_valid;
  logic [COUNTER_BITS-1:0] in_now;
  logic                    out_valid;
  res_t                    out_res;
  res_t                    core_res;
  logic                    advance;

  frds_cfg #(.COUNTER_BITS(COUNTER_BITS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .mask      (mask)
  );

  frds_core #(.COUNTER_BITS(COUNTER_BITS)) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .mask     (mask),
    .step     (advance),
    .now_time (in_now),
    .res      (core_res)
  );

  // handshake: the poll stage moves on whenever the result slot frees up
  assign advance    = in_valid && (!out_valid || result.ready);
  assign poll.ready = !in_valid || advance;

  // poll register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (poll.ready) begin
      in_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      in_now <= poll.now_time[COUNTER_BITS-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign result.valid          = out_valid;
  assign result.fired          = out_res.fired;
  assign result.interval       = out_res.interval;
  assign result.lateness       = out_res.lateness;
  assign result.overran        = out_res.overran;
  assign result.release_count  = out_res.release_count;
  assign result.overrun_count  = out_res.overrun_count;
  assign result.worst_lateness = out_res.worst_lateness;
  assign result.period_error   = out_res.period_error;

  // checks on the scheduling logic
  `FRDS_ASSERT_NOW(a_err_never_fires, out_valid && out_res.period_error, !out_res.fired, "release reported with a bad period")
  `FRDS_ASSERT_NOW(a_overrun_is_release, out_valid && out_res.overran, out_res.fired, "overrun flagged without a release")
  `FRDS_ASSERT_NOW(a_worst_bounds_late, out_valid, out_res.lateness <= out_res.worst_lateness, "lateness above worst lateness")
  `FRDS_ASSERT_NEXT(a_stalled_poll_held, in_valid && !advance, in_valid && $stable(in_now), "stalled poll lost")

endmodule

// ===== hw/rtl/frds_cfg.sv =====
// configuration registers, effective counter mask and period check
module frds_cfg
  import frds_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [31:0]               cfg_data,
  output cfg_t                      cfg,
  output logic [COUNTER_BITS-1:0]   mask
);

  logic [31:0]             period;
  logic [COUNTER_BITS-1:0] mask_next;

  // fill ones below the highest set bit, never narrower than 16 bits
  function automatic logic [COUNTER_BITS-1:0] fill_mask(input logic [COUNTER_BITS-1:0] v);
    logic [COUNTER_BITS-1:0] m;
    m = v | COUNTER_BITS'(MIN_MASK);
    for (int s = 1; s < int'(COUNTER_BITS); s = s * 2) begin
      m = m | (m >> s);
    end
    return m;
  endfunction

  assign mask_next = fill_mask(cfg_data[COUNTER_BITS-1:0]);

  // register writes; the mask is stored already normalized
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= RESET_PERIOD;
      mask   <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PERIOD:       period <= cfg_data;
        REG_COUNTER_MASK: mask   <= mask_next;
        default: ;
      endcase
    end
  end

  // period must be nonzero and within half the counter range
  assign cfg.period     = period;
  assign cfg.period_err = (period == '0) || (period > 32'(mask >> 1));
  assign cfg.restart    = cfg_we && (cfg_index == REG_PERIOD);

endmodule

// ===== hw/rtl/frds_core.sv =====
// schedule state and the per-poll release decision
module frds_core
  import frds_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic [COUNTER_BITS-1:0] mask,
  input  logic                    step,
  input  logic [COUNTER_BITS-1:0] now_time,
  output res_t                    res
);

  logic [COUNTER_BITS-1:0] deadline, deadline_next;
  logic [COUNTER_BITS-1:0] previous_release, previous_release_next;
  logic                    started, started_next;
  logic [31:0]             releases, releases_next;
  logic [31:0]             overruns, overruns_next;
  logic [COUNTER_BITS-1:0] worst_late, worst_late_next;

  logic [COUNTER_BITS-1:0] half;
  logic [COUNTER_BITS-1:0] now;
  logic [COUNTER_BITS-1:0] per;
  logic [COUNTER_BITS-1:0] late_by;
  logic [COUNTER_BITS-1:0] gap;
  logic                    due;

  assign half    = mask >> 1;
  assign now     = now_time & mask;
  // a valid period is at most half the mask, so the low bits carry it all
  assign per     = cfg.period[COUNTER_BITS-1:0];
  assign late_by = (now - deadline) & mask;
  assign gap     = (now - previous_release) & mask;
  assign due     = late_by <= half;

  // release decision and next schedule state
  always_comb begin
    deadline_next         = deadline;
    previous_release_next = previous_release;
    started_next          = started;
    releases_next         = releases;
    overruns_next         = overruns;
    worst_late_next       = worst_late;
    res.fired             = 1'b0;
    res.interval          = '0;
    res.lateness          = '0;
    res.overran           = 1'b0;
    if (!cfg.period_err) begin
      if (!started) begin
        previous_release_next = now;
        deadline_next         = (now + per) & mask;
        started_next          = 1'b1;
        releases_next         = 32'd1;
        res.fired             = 1'b1;
        res.interval          = cfg.period;
      end else if (due) begin
        res.fired             = 1'b1;
        res.lateness          = 32'(late_by);
        res.interval          = 32'(gap);
        previous_release_next = now;
        releases_next         = releases + 32'd1;
        if (late_by > worst_late) begin
          worst_late_next = late_by;
        end
        if (late_by >= per) begin
          // overrun: rebase on the poll time instead of firing the backlog
          res.overran   = 1'b1;
          overruns_next = overruns + 32'd1;
          deadline_next = (now + per) & mask;
        end else begin
          deadline_next = (deadline + per) & mask;
        end
      end
    end
    res.release_count  = releases_next;
    res.overrun_count  = overruns_next;
    res.worst_lateness = 32'(worst_late_next);
    res.period_error   = cfg.period_err;
  end

  // state update; a period write restarts the schedule
  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      deadline         <= '0;
      previous_release <= '0;
      started          <= 1'b0;
      releases         <= '0;
      overruns         <= '0;
      worst_late       <= '0;
    end else if (step) begin
      deadline         <= deadline_next;
      previous_release <= previous_release_next;
      started          <= started_next;
      releases         <= releases_next;
      overruns         <= overruns_next;
      worst_late       <= worst_late_next;
    end
  end

endmodule
